FILE: sv/block_byte_permutation_cipher_defines.svh
// Assertion macros shared by the block byte permutation cipher modules.
// Depends on nothing; included by the modules that carry assertions.
`ifndef BLOCK_BYTE_PERMUTATION_CIPHER_DEFINES_SVH
`define BLOCK_BYTE_PERMUTATION_CIPHER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbpc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BBPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbpc assertion failed");

`endif

FILE: sv/bbpc_pkg.sv
// Shared types and constants for the block byte permutation cipher.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package bbpc_pkg;

    localparam int MAX_BLOCK = 16;
    localparam int MIN_BLOCK = 2;
    localparam int LEN_W     = 5;
    localparam int POS_W     = 4;

    localparam logic [7:0]       PAD_BYTE = 8'h20;
    localparam logic [LEN_W-1:0] LEN_MIN  = LEN_W'(MIN_BLOCK);
    localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_BLOCK);

    localparam logic [1:0] REG_BLOCK_LENGTH = 2'd0;
    localparam logic [1:0] REG_PERM_TABLE   = 2'd1;
    localparam logic [1:0] REG_DECRYPT_MODE = 2'd2;

    typedef logic [MAX_BLOCK-1:0][7:0]       blk_t;
    typedef logic [MAX_BLOCK-1:0][POS_W-1:0] perm_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        perm_t            perm;
        logic             decrypt;
    } cfg_t;

endpackage

FILE: sv/bbpc_front.sv
// Front end: gathers message bytes into a block and pads a finished block.
// Depends on bbpc_pkg; pushes finished blocks into bbpc_queue.
`timescale 1ns / 1ps

module bbpc_front (
    input  logic           clk,
    input  logic           rst_n,
    input  bbpc_pkg::cfg_t cfg,
    input  logic           in_fire,
    input  logic [7:0]     data_byte,
    input  logic           msg_end,
    output logic           push,
    output bbpc_pkg::blk_t push_data
);
    import bbpc_pkg::*;

    logic [LEN_W-1:0] fill_count_reg;
    logic [LEN_W-1:0] fill_count_next;
    blk_t             buf_reg;
    blk_t             buf_next;
    logic [LEN_W-1:0] count;
    logic             complete;

    always_comb
    begin
        buf_next = buf_reg;
        if (fill_count_reg < cfg.len)
        begin
            buf_next[fill_count_reg[POS_W-1:0]] = data_byte;
        end
        count    = fill_count_reg + LEN_W'(1);
        complete = !(count < cfg.len) || msg_end;
        for (int i = 0; i < MAX_BLOCK; i++)
        begin
            if ((LEN_W'(i) < count) && (LEN_W'(i) < cfg.len))
            begin
                push_data[i] = buf_next[i];
            end
            else
            begin
                push_data[i] = PAD_BYTE;
            end
        end
        push            = in_fire && complete;
        fill_count_next = fill_count_reg;
        if (in_fire)
        begin
            fill_count_next = complete ? '0 : count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            buf_reg <= buf_next;
        end
    end

endmodule

FILE: sv/bbpc_queue.sv
// Two-entry queue of padded blocks between the front end and the back end.
// Depends on bbpc_pkg and the assertion macros header.
`timescale 1ns / 1ps

`include "block_byte_permutation_cipher_defines.svh"

module bbpc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bbpc_pkg::blk_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output bbpc_pkg::blk_t head
);
    import bbpc_pkg::*;

    localparam int DEPTH = 2;

    blk_t        mem_reg [DEPTH];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    assign full  = (count_reg == 2'(DEPTH));
    assign valid = (count_reg != 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `BBPC_ASSERT_NOW(a_no_push_when_full, clk, rst_n, full, !push)
    `BBPC_ASSERT_NOW(a_no_pop_when_empty, clk, rst_n, !valid, !pop)
    `BBPC_ASSERT_NOW(a_count_in_range, clk, rst_n, 1'b1, count_reg <= 2'(DEPTH))
    `BBPC_ASSERT_NOW(a_ptrs_match_count, clk, rst_n, count_reg == 2'(DEPTH) || count_reg == 2'd0,
                     wr_ptr_reg == rd_ptr_reg)

endmodule

FILE: sv/bbpc_back.sv
// Back end: sends the head block out one permuted byte per cycle while the output is not stalled.
// Depends on bbpc_pkg, the assertion macros header, and the head of bbpc_queue.
`timescale 1ns / 1ps

`include "block_byte_permutation_cipher_defines.svh"

module bbpc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  bbpc_pkg::cfg_t cfg,
    input  logic           q_valid,
    input  bbpc_pkg::blk_t q_head,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_byte,
    output logic           block_done
);
    import bbpc_pkg::*;

    logic [POS_W-1:0] k_reg;
    logic [POS_W-1:0] k_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_byte_reg;
    logic             block_done_reg;
    logic             fire;
    logic             last;
    logic [POS_W-1:0] src;
    logic [7:0]       res;

    always_comb
    begin
        fire = q_valid && (!out_valid_reg || out_ready);
        last = ({1'b0, k_reg} == (cfg.len - LEN_W'(1)));
        src  = cfg.perm[k_reg];
        if (cfg.decrypt)
        begin
            res = PAD_BYTE;
            for (int j = 0; j < MAX_BLOCK; j++)
            begin
                if ((LEN_W'(j) < cfg.len) && (cfg.perm[j] == k_reg))
                begin
                    res = q_head[j];
                end
            end
        end
        else
        begin
            res = ({1'b0, src} < cfg.len) ? q_head[src] : PAD_BYTE;
        end
        pop            = fire && last;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            k_next         = last ? '0 : k_reg + POS_W'(1);
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_byte_reg   <= res;
            block_done_reg <= last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign block_done = block_done_reg;

    `BBPC_ASSERT_NOW(a_idle_index_zero, clk, rst_n, !q_valid, k_reg == '0)
    `BBPC_ASSERT_NEXT(a_pop_marks_done, clk, rst_n, pop, out_valid && block_done && k_reg == '0)
    `BBPC_ASSERT_NOW(a_index_below_len, clk, rst_n, q_valid, {1'b0, k_reg} < cfg.len)

endmodule

FILE: sv/block_byte_permutation_cipher.sv
// Top level of the block byte permutation cipher: configuration registers and wiring.
// Depends on bbpc_pkg, bbpc_front, bbpc_queue and bbpc_back.
//
//   Channel   Direction   Handshake             Payload
//   in        input       in_valid / in_ready   data_byte, msg_end
//   out       output      out_valid / out_ready out_byte, block_done
//   cfg       input       cfg_wr_en             cfg_index, cfg_data
//
// Input bytes are taken one per cycle while the two-entry block queue has room.
// A block of N bytes leaves as N output transactions, one per cycle while the output is not stalled.
// A finished block is written into the block queue, then sent byte by byte through the back end's output register.
// Reset clears the fill count, the queue and the output valid flag, and sets the configuration to its defaults.
// A stalled output only stops input once both queued blocks are waiting.
`timescale 1ns / 1ps

module block_byte_permutation_cipher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        msg_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        block_done,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import bbpc_pkg::*;

    logic [LEN_W-1:0] block_length_reg;
    perm_t            perm_table_reg;
    logic             decrypt_mode_reg;
    logic [LEN_W-1:0] eff_len;
    cfg_t             cfg;
    logic             in_fire;
    logic             push;
    blk_t             push_data;
    logic             q_full;
    logic             q_valid;
    logic             pop;
    blk_t             q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_length_reg <= LEN_MIN;
            perm_table_reg   <= perm_t'(64'h10);
            decrypt_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_BLOCK_LENGTH: block_length_reg <= cfg_data[LEN_W-1:0];
                REG_PERM_TABLE:   perm_table_reg   <= perm_t'(cfg_data);
                REG_DECRYPT_MODE: decrypt_mode_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        if (block_length_reg < LEN_MIN)
        begin
            eff_len = LEN_MIN;
        end
        else if (block_length_reg > LEN_MAX)
        begin
            eff_len = LEN_MAX;
        end
        else
        begin
            eff_len = block_length_reg;
        end
        cfg.len     = eff_len;
        cfg.perm    = perm_table_reg;
        cfg.decrypt = decrypt_mode_reg;
    end

    assign in_ready = !q_full;
    assign in_fire  = in_valid && in_ready;

    bbpc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_fire   (in_fire),
        .data_byte (data_byte),
        .msg_end   (msg_end),
        .push      (push),
        .push_data (push_data)
    );

    bbpc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    bbpc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .block_done (block_done)
    );

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for block_byte_permutation_cipher: directed cases, then random traffic.
// Depends on bbpc_pkg and the cipher RTL; a built-in predictor supplies the expected output bytes.
`timescale 1ns / 1ps

module testbench;
    import bbpc_pkg::*;

    localparam int RANDOM_ITEMS  = 410;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 4000;
    localparam int MAX_PRINTED   = 40;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } cipher_out_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        msg_end;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        block_done;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    logic [LEN_W-1:0] cur_len     = LEN_MIN;
    perm_t            cur_perm    = 64'h10;
    logic             cur_decrypt = 1'b0;
    logic [LEN_W-1:0] gathered    = '0;
    blk_t             held_bytes;

    cipher_out_t permuted_q[$];
    cipher_out_t check_item;
    int          err_count    = 0;
    int          quiet_cycles = 0;
    int          tx_calm      = 0;
    int          rx_left      = 0;
    int          rx_pick;

    block_byte_permutation_cipher dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .msg_end    (msg_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .block_done (block_done),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int eff_len(logic [LEN_W-1:0] l);
        if (l < LEN_MIN)
            return MIN_BLOCK;
        if (l > LEN_MAX)
            return MAX_BLOCK;
        return int'(l);
    endfunction

    // Gathers one byte and, when a block closes, queues its bytes in output order.
    function automatic void predict_byte(logic [7:0] value, logic last);
        int   len;
        int   pos;
        int   count;
        blk_t blk;
        blk_t res;
        logic [POS_W-1:0] e;
        cipher_out_t      o_item;
        len = eff_len(cur_len);
        pos = int'(gathered);
        if (pos < len)
            held_bytes[pos] = value;
        count = pos + 1;
        if (count < len && !last)
        begin
            gathered = LEN_W'(count);
            return;
        end
        for (int i = 0; i < MAX_BLOCK; i++)
            blk[i] = (i < count && i < len) ? held_bytes[i] : PAD_BYTE;
        for (int i = 0; i < MAX_BLOCK; i++)
            res[i] = PAD_BYTE;
        for (int i = 0; i < len; i++)
        begin
            e = cur_perm[i];
            if (cur_decrypt)
            begin
                if (int'(e) < len)
                    res[e] = blk[i];
            end
            else
                res[i] = (int'(e) < len) ? blk[e] : PAD_BYTE;
        end
        for (int i = 0; i < len; i++)
        begin
            o_item.value = res[i];
            o_item.last  = (i == len - 1);
            permuted_q.insert(permuted_q.size(), o_item);
        end
        gathered = '0;
    endfunction

    function automatic perm_t shuffled_perm(int n);
        perm_t            p;
        int               j;
        logic [POS_W-1:0] t;
        for (int i = 0; i < MAX_BLOCK; i++)
            p[i] = POS_W'(i);
        for (int i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = p[i];
            p[i] = p[j];
            p[j] = t;
        end
        for (int i = n; i < MAX_BLOCK; i++)
            p[i] = POS_W'($urandom);
        return p;
    endfunction

    function automatic int pick_tx_gap();
        int r;
        if (tx_calm > 0)
        begin
            tx_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            tx_calm = $urandom_range(10, 40);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic report_mismatch(string msg);
        if (err_count < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_byte(logic [7:0] value, logic last);
        int gap;
        gap = pick_tx_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= value;
        msg_end   <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_byte(value, last);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (permuted_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_BLOCK_LENGTH: cur_len = val[LEN_W-1:0];
            REG_PERM_TABLE:   cur_perm = val;
            REG_DECRYPT_MODE: cur_decrypt = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic test_reset_defaults();
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h00, 1'b1);
        wait_idle();
    endtask

    task automatic test_length_clamping();
        write_cfg(REG_BLOCK_LENGTH, 64'd0);
        write_cfg(REG_PERM_TABLE, 64'h01);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        wait_idle();
        write_cfg(REG_BLOCK_LENGTH, 64'd31);
        write_cfg(REG_PERM_TABLE, 64'h0123456789ABCDEF);
        write_cfg(REG_DECRYPT_MODE, 64'd1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7E, 1'b0);
        send_byte(8'hC3, 1'b1);
        wait_idle();
    endtask

    task automatic test_out_of_range_entries();
        write_cfg(REG_BLOCK_LENGTH, 64'd1);
        write_cfg(REG_PERM_TABLE, 64'h0F);
        write_cfg(REG_DECRYPT_MODE, 64'd0);
        send_byte(8'hB0, 1'b0);
        send_byte(8'h4C, 1'b0);
        wait_idle();
    endtask

    // Two bytes name the same slot, one names a slot past the end, two slots stay empty.
    task automatic test_decrypt_collisions();
        write_cfg(REG_BLOCK_LENGTH, 64'd4);
        write_cfg(REG_PERM_TABLE, 64'h2711);
        write_cfg(REG_DECRYPT_MODE, 64'd1);
        send_byte(8'h10, 1'b0);
        send_byte(8'h21, 1'b0);
        send_byte(8'h32, 1'b0);
        send_byte(8'h43, 1'b0);
        wait_idle();
    endtask

    task automatic test_length_lowered();
        write_cfg(REG_BLOCK_LENGTH, 64'd8);
        write_cfg(REG_PERM_TABLE, 64'hFEDCBA9876543210);
        write_cfg(REG_DECRYPT_MODE, 64'd0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h44, 1'b0);
        send_byte(8'h55, 1'b0);
        wait_idle();
        write_cfg(REG_BLOCK_LENGTH, 64'd3);
        send_byte(8'h66, 1'b0);
        wait_idle();
    endtask

    // Each phase picks a new setting and, once per phase, holds the sender until the
    // output has drained.
    task automatic test_random_traffic();
        int               phase;
        int               sent;
        int               n_items;
        int               pause_at;
        int               r;
        logic [LEN_W-1:0] l;
        perm_t            p;
        phase = 0;
        sent  = 0;
        while (sent < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (phase == 0)
                l = LEN_MIN;
            else if (phase == 1)
                l = LEN_MAX;
            else if (r < 45)
                l = LEN_W'($urandom_range(2, 6));
            else if (r < 70)
                l = LEN_W'($urandom_range(7, 15));
            else if (r < 85)
                l = LEN_MAX;
            else if (r < 93)
                l = LEN_W'($urandom_range(0, 1));
            else
                l = LEN_W'($urandom_range(17, 31));
            if ($urandom_range(0, 4) == 0)
                p = {$urandom, $urandom};
            else
                p = shuffled_perm(eff_len(l));
            write_cfg(REG_BLOCK_LENGTH, 64'(l));
            write_cfg(REG_PERM_TABLE, p);
            write_cfg(REG_DECRYPT_MODE, 64'(phase == 1 || $urandom_range(0, 1) == 1));
            n_items = $urandom_range(20, 70);
            if (n_items > RANDOM_ITEMS - sent)
                n_items = RANDOM_ITEMS - sent;
            pause_at = $urandom_range(1, n_items - 1);
            for (int k = 0; k < n_items; k++)
            begin
                if (k == pause_at)
                    wait_idle();
                send_byte(8'($urandom), $urandom_range(0, 11) == 0);
            end
            sent += n_items;
            wait_idle();
            phase++;
        end
    endtask

    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_pick = $urandom_range(0, 99);
            if (rx_pick < 55)
            begin
                out_ready <= 1'b1;
                rx_left = $urandom_range(1, 12);
            end
            else if (rx_pick < 62)
            begin
                out_ready <= 1'b1;
                rx_left = $urandom_range(30, 80);
            end
            else if (rx_pick < 95)
            begin
                out_ready <= 1'b0;
                rx_left = $urandom_range(1, 3);
            end
            else
            begin
                out_ready <= 1'b0;
                rx_left = $urandom_range(10, 30);
            end
        end
        else
            rx_left = rx_left - 1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (permuted_q.size() == 0)
                report_mismatch($sformatf("unexpected output transaction, out_byte %h", out_byte));
            else
            begin
                check_item = permuted_q.pop_front();
                if (out_byte !== check_item.value)
                    report_mismatch($sformatf("out_byte %h, expected %h",
                                              out_byte, check_item.value));
                if (block_done !== check_item.last)
                    report_mismatch($sformatf("block_done %b, expected %b",
                                              block_done, check_item.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles, %0d outputs outstanding",
                     QUIET_LIMIT, permuted_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        data_byte = 8'h00;
        msg_end   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_BLOCK_LENGTH;
        cfg_data  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_defaults();
        test_length_clamping();
        test_out_of_range_entries();
        test_decrypt_collisions();
        test_length_lowered();
        test_random_traffic();
        wait_idle();
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
